/* design/gdda_pkg.sv */
// Shared types, codes and calendar helpers for the Gregorian date day-count block.
// No dependencies; imported by gdda_leap and the top level.
`timescale 1ns / 1ps

package gdda_pkg;

  localparam int EPOCH_YEAR     = 2000;
  localparam int DEF_YEAR_SPAN  = 256;
  localparam int DAY_W          = 5;
  localparam int MONTH_W        = 4;
  localparam int GYEAR_W        = 14;
  localparam int AMOUNT_W       = 17;
  localparam int CUR_YEAR_W     = 12;
  localparam int DIFF_W         = 18;
  localparam int YLEN_W         = 9;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_CMP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_BEFORE   = 2'd2,
    ST_PAST     = 2'd3
  } status_t;

  // control from the sequencer to the year/leap tracker
  typedef struct packed {
    logic clr;
    logic step;
  } leap_ctl_t;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [YLEN_W-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

/* design/gdda_alu.sv */
// Add/subtract unit shared by the steps of the day-count sequencer.
// Depends on nothing; the top level sizes it.
`timescale 1ns / 1ps

module gdda_alu #(
  parameter int W = 18
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W:0]   res
);

  logic [W:0] b_ext;

  // subtract as a + ~b + 1; bit W is then the sign, i.e. a < b
  assign b_ext = sub ? ~{1'b0, b} : {1'b0, b};
  assign res   = {1'b0, a} + b_ext + {{W{1'b0}}, sub};

endmodule

/* design/gdda_leap.sv */
// Year walker: counts year offsets from the epoch and tracks the leap rule
// with residue counters (mod 4, mod 100, centuries mod 4). Uses gdda_pkg.
`timescale 1ns / 1ps

module gdda_leap
  import gdda_pkg::*;
#(
  parameter int YW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  leap_ctl_t     ctl,
  output logic [YW-1:0] yc,
  output logic          leap
);

  logic [1:0] r4;
  logic [6:0] r100;
  logic [1:0] q4;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      yc   <= '0;
      r4   <= '0;
      r100 <= '0;
      q4   <= '0;
    end else if (ctl.step) begin
      yc <= yc + 1'b1;
      r4 <= r4 + 2'd1;
      if (r100 == 7'd99) begin
        r100 <= '0;
        q4   <= q4 + 2'd1;
      end else begin
        r100 <= r100 + 7'd1;
      end
    end
  end

  // epoch year is a multiple of 400, so offset residues give the leap rule directly
  assign leap = ((r4 == 2'd0) && (r100 != 7'd0)) || ((r100 == 7'd0) && (q4 == 2'd0));

endmodule

/* design/gregorian_date_day_arithmetic.sv */
// Gregorian date keeper with day arithmetic, day counts from 2000-01-01.
// Input channel (in_valid / in_stall) carries one command item: load a date,
// add days, subtract days, or compare with a given date. Output channel
// (out_valid / out_stall) returns one result item per command: the current
// date, its leap flag, a status code and, on compare, the signed difference.
// in_stall is high during reset and while an item is being worked.
// Work per item:
//   add / subtract : adjust the count, then walk the result's years, months
//   load           : walk the years and months up to the given date
//   compare        : as load, then a subtraction in the shared adder
//   refused or invalid cases finish early.
// The year walk runs one year per cycle through the single shared adder,
// then one month per cycle. The next item can be accepted in the cycle in
// which out_valid rises, once the last result is registered.
// A finished result sits in the output register; the next item may be
// accepted meanwhile, and it completes only once that register is taken.
// While out_stall is high the result and out_valid hold.
// Reset (rst, synchronous) sets the current date to 2000-01-01 and empties
// the output register; there is no clearing pass.
// Depends on gdda_pkg, gdda_alu and gdda_leap.
`timescale 1ns / 1ps

module gregorian_date_day_arithmetic
  import gdda_pkg::*;
#(
  parameter int YEAR_SPAN = DEF_YEAR_SPAN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              cmd,
  input  logic [DAY_W-1:0]        given_day,
  input  logic [MONTH_W-1:0]      given_month,
  input  logic [GYEAR_W-1:0]      given_year,
  input  logic [AMOUNT_W-1:0]     day_amount,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DAY_W-1:0]        cur_day,
  output logic [MONTH_W-1:0]      cur_month,
  output logic [CUR_YEAR_W-1:0]   cur_year,
  output logic                    leap_flag,
  output logic [1:0]              status,
  output logic signed [DIFF_W-1:0] day_difference,
  output logic                    is_less,
  output logic                    is_equal
);

  localparam int YW = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
  localparam int SPAN_DAYS = 365 * YEAR_SPAN + (YEAR_SPAN + 3) / 4
                             - (YEAR_SPAN + 99) / 100 + (YEAR_SPAN + 399) / 400;
  localparam int CNT_W = $clog2(SPAN_DAYS);
  localparam int W = ((CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W) + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_YWALK = 10'b00_0000_0010,
    S_CHECK = 10'b00_0000_0100,
    S_MWALK = 10'b00_0000_1000,
    S_DADD  = 10'b00_0001_0000,
    S_CMP   = 10'b00_0010_0000,
    S_ADJ   = 10'b00_0100_0000,
    S_FYEAR = 10'b00_1000_0000,
    S_FMON  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // latched item
  cmd_t                cmd_q;
  logic [DAY_W-1:0]    gd_q;
  logic [MONTH_W-1:0]  gm_q;
  logic [GYEAR_W-1:0]  gy_q;
  logic [AMOUNT_W-1:0] amt_q;

  // working registers
  logic [W-1:0]        acc;
  logic [MONTH_W-1:0]  m_cnt;
  status_t             st_q;
  logic [DIFF_W-1:0]   diff_q;
  logic                less_q;
  logic                equal_q;

  // current date
  logic [DAY_W-1:0]    day_reg;
  logic [MONTH_W-1:0]  month_reg;
  logic [YW-1:0]       year_offset_reg;
  logic                leap_reg;
  logic [CNT_W-1:0]    count_reg;

  logic [W-1:0]        alu_a;
  logic [W-1:0]        alu_b;
  logic                alu_sub;
  logic [W:0]          alu_res;
  logic                borrow;

  leap_ctl_t           lctl;
  logic [YW-1:0]       yc;
  logic                tleap;

  logic                accept;
  logic                year_ok;
  logic [YW-1:0]       gyoff;
  logic                date_ok;
  logic [DAY_W-1:0]    glen;
  logic                out_free;

  gdda_alu #(.W(W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  gdda_leap #(.YW(YW)) u_leap (
    .clk  (clk),
    .rst  (rst),
    .ctl  (lctl),
    .yc   (yc),
    .leap (tleap)
  );

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign borrow   = alu_res[W];

  assign year_ok = (given_year >= GYEAR_W'(EPOCH_YEAR))
                && ({1'b0, given_year} < (GYEAR_W + 1)'(EPOCH_YEAR + YEAR_SPAN));
  assign gyoff   = YW'(gy_q - GYEAR_W'(EPOCH_YEAR));

  assign glen    = month_len(gm_q, tleap);
  assign date_ok = (gm_q >= MONTH_FIRST) && (gm_q <= MONTH_LAST)
                && (gd_q != '0) && (gd_q <= glen);

  // operand selection for the shared adder
  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    lctl    = '{clr: accept, step: 1'b0};
    unique case (state)
      S_YWALK: begin
        alu_b     = W'(year_len(tleap));
        lctl.step = (yc != gyoff);
      end
      S_MWALK: alu_b = W'(month_len(m_cnt, tleap));
      S_DADD:  alu_b = W'(gd_q - 5'd1);
      S_CMP: begin
        alu_a   = W'(count_reg);
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      S_ADJ: begin
        alu_a   = W'(count_reg);
        alu_b   = W'(amt_q);
        alu_sub = (cmd_q == CMD_SUB);
      end
      S_FYEAR: begin
        alu_b     = W'(year_len(tleap));
        alu_sub   = 1'b1;
        lctl.step = (yc != YW'(YEAR_SPAN - 1)) && !borrow;
      end
      S_FMON: begin
        alu_b   = W'(month_len(m_cnt, tleap));
        alu_sub = 1'b1;
      end
      S_IDLE, S_CHECK, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      day_reg         <= 5'd1;
      month_reg       <= MONTH_FIRST;
      year_offset_reg <= '0;
      leap_reg        <= 1'b1;
      count_reg       <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_t'(cmd);
            gd_q    <= given_day;
            gm_q    <= given_month;
            gy_q    <= given_year;
            amt_q   <= day_amount;
            acc     <= '0;
            m_cnt   <= MONTH_FIRST;
            diff_q  <= '0;
            less_q  <= 1'b0;
            equal_q <= 1'b0;
            if (cmd_t'(cmd) == CMD_ADD || cmd_t'(cmd) == CMD_SUB) begin
              st_q  <= ST_OK;
              state <= S_ADJ;
            end else if (year_ok) begin
              st_q  <= ST_OK;
              state <= S_YWALK;
            end else if (cmd_t'(cmd) == CMD_LOAD) begin
              st_q            <= ST_INVALID;
              day_reg         <= 5'd1;
              month_reg       <= MONTH_FIRST;
              year_offset_reg <= '0;
              leap_reg        <= 1'b1;
              count_reg       <= '0;
              state           <= S_DONE;
            end else begin
              st_q  <= ST_INVALID;
              state <= S_CMP;
            end
          end
        end
        S_YWALK: begin
          if (yc == gyoff) begin
            state <= S_CHECK;
          end else begin
            acc <= alu_res[W-1:0];
          end
        end
        S_CHECK: begin
          if (date_ok) begin
            state <= S_MWALK;
          end else if (cmd_q == CMD_LOAD) begin
            st_q            <= ST_INVALID;
            day_reg         <= 5'd1;
            month_reg       <= MONTH_FIRST;
            year_offset_reg <= '0;
            leap_reg        <= 1'b1;
            count_reg       <= '0;
            state           <= S_DONE;
          end else begin
            // invalid compared date counts as the epoch
            st_q  <= ST_INVALID;
            acc   <= '0;
            state <= S_CMP;
          end
        end
        S_MWALK: begin
          if (m_cnt == gm_q) begin
            state <= S_DADD;
          end else begin
            acc   <= alu_res[W-1:0];
            m_cnt <= m_cnt + 4'd1;
          end
        end
        S_DADD: begin
          acc <= alu_res[W-1:0];
          if (cmd_q == CMD_LOAD) begin
            day_reg         <= gd_q;
            month_reg       <= gm_q;
            year_offset_reg <= gyoff;
            leap_reg        <= tleap;
            count_reg       <= CNT_W'(alu_res);
            state           <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          diff_q  <= alu_res[DIFF_W-1:0];
          less_q  <= borrow;
          equal_q <= (alu_res == '0);
          state   <= S_DONE;
        end
        S_ADJ: begin
          if (cmd_q == CMD_SUB && borrow) begin
            st_q  <= ST_BEFORE;
            state <= S_DONE;
          end else if (cmd_q == CMD_ADD && alu_res >= (W + 1)'(SPAN_DAYS)) begin
            st_q  <= ST_PAST;
            state <= S_DONE;
          end else begin
            acc       <= alu_res[W-1:0];
            count_reg <= CNT_W'(alu_res);
            state     <= S_FYEAR;
          end
        end
        S_FYEAR: begin
          if (lctl.step) begin
            acc <= alu_res[W-1:0];
          end else begin
            state <= S_FMON;
          end
        end
        S_FMON: begin
          if (m_cnt != MONTH_LAST && !borrow) begin
            acc   <= alu_res[W-1:0];
            m_cnt <= m_cnt + 4'd1;
          end else begin
            // remainder is below the month length here
            day_reg         <= acc[DAY_W-1:0] + 5'd1;
            month_reg       <= m_cnt;
            year_offset_reg <= yc;
            leap_reg        <= tleap;
            state           <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded as the item completes
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cur_day        <= day_reg;
      cur_month      <= month_reg;
      cur_year       <= CUR_YEAR_W'(EPOCH_YEAR + int'(year_offset_reg));
      leap_flag      <= leap_reg;
      status         <= st_q;
      day_difference <= diff_q;
      is_less        <= less_q;
      is_equal       <= equal_q;
    end
  end

endmodule
